/* rtl/olirs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package olirs_pkg;

   localparam int ELEM_W     = 32;
   localparam int GROUP_SIZE = 8;
   localparam int GROUP_IW   = $clog2(GROUP_SIZE);

   // request action codes
   localparam logic [2:0] ACT_APPEND = 3'd0;
   localparam logic [2:0] ACT_INSERT = 3'd1;
   localparam logic [2:0] ACT_REMOVE = 3'd2;
   localparam logic [2:0] ACT_GET    = 3'd3;
   localparam logic [2:0] ACT_FIND   = 3'd4;
   localparam logic [2:0] ACT_CLEAR  = 3'd5;

   // result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [2:0]               action;
      logic [6:0]               position;
      logic signed [ELEM_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [ELEM_W-1:0] read_value;
      logic                     found;
      logic [5:0]               found_index;
      logic [6:0]               count;
      logic [1:0]               status;
   } rsp_type;

   // operation broadcast to every cell of the chain
   typedef enum logic [2:0] {
      CELL_IDLE,
      CELL_INSERT,
      CELL_REMOVE,
      CELL_GET,
      CELL_FIND,
      CELL_QUIET
   } cell_op_type;

   typedef struct packed {
      cell_op_type              op;
      logic signed [ELEM_W-1:0] value;
   } cell_cmd_type;

   // reduced view of one group of cells
   typedef struct packed {
      logic                     any;
      logic [GROUP_IW-1:0]      first;
      logic signed [ELEM_W-1:0] data;
   } grp_type;

endpackage

`default_nettype wire

/* rtl/olirs_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module olirs_cell
   import olirs_pkg::*;
#(
   parameter int IW    = 6,
   parameter int CW    = 7,
   parameter int INDEX = 0
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire cell_cmd_type             cmd,
   input  wire logic [IW-1:0]            pos,
   input  wire logic [CW-1:0]            count,
   input  wire logic signed [ELEM_W-1:0] prev_data,
   input  wire logic signed [ELEM_W-1:0] next_data,
   output logic signed [ELEM_W-1:0]      data,
   output logic                          hit
);

   localparam logic [IW-1:0] IDX   = IW'(INDEX);
   localparam logic [CW-1:0] IDX_C = CW'(INDEX);

   logic signed [ELEM_W-1:0] data_ff, data_in;
   logic                     hit_ff, hit_in;

   always_comb begin
      data_in = data_ff;
      hit_in  = hit_ff;
      case (cmd.op)
         CELL_INSERT: begin
            hit_in = 1'b0;
            if (IDX > pos) begin
               data_in = prev_data;
            end else if (IDX == pos) begin
               data_in = cmd.value;
            end
         end
         CELL_REMOVE: begin
            hit_in = 1'b0;
            if (IDX >= pos) begin
               data_in = next_data;
            end
         end
         CELL_GET:   hit_in = (IDX == pos);
         CELL_FIND:  hit_in = (IDX_C < count) && (data_ff == cmd.value);
         CELL_QUIET: hit_in = 1'b0;
         default: begin
            data_in = data_ff;
            hit_in  = hit_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   assign data = data_ff;
   assign hit  = hit_ff;

endmodule

`default_nettype wire

/* rtl/olirs_group.sv */
`timescale 1ns / 1ps
`default_nettype none

module olirs_group
   import olirs_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic signed [ELEM_W-1:0] data [GROUP_SIZE],
   input  wire logic [GROUP_SIZE-1:0]    hit,
   output grp_type                       grp
);

   grp_type grp_ff, grp_in;

   // lowest hit wins; data is the or of hit-gated words
   always_comb begin
      grp_in.any   = |hit;
      grp_in.first = '0;
      grp_in.data  = '0;
      for (int i = GROUP_SIZE - 1; i >= 0; i--) begin
         if (hit[i]) begin
            grp_in.first = GROUP_IW'(i);
         end
      end
      for (int i = 0; i < GROUP_SIZE; i++) begin
         grp_in.data = grp_in.data | (hit[i] ? data[i] : '0);
      end
   end

   always_ff @(posedge clock) begin
      grp_ff <= grp_in;
   end

   assign grp = grp_ff;

endmodule

`default_nettype wire

/* rtl/ordered_list_insert_remove_search.sv */
`timescale 1ns / 1ps
`default_nettype none

// bounded ordered list of signed 32-bit elements with a count
// request channel (req_valid / req_ready / req_data) carries action,
// position and value; every request transfer gives exactly one response
// transfer on rsp_valid / rsp_ready / rsp_data
// the list is a chain of DEPTH cells, one element each; insert shifts the
// cells above the position up by one, remove shifts them down, all cells
// moving in the same cycle
// get and find mark hits in the cells, then a registered reduction over
// groups of eight cells and a final pick across the groups form the result
// the request is registered, then runs through the exec, group reduce and
// final pick states into the response register; req_ready is high only
// when no request is in flight (exec, group reduce, final pick)
// the response sits in an output register, so a request may be taken while
// the previous response still waits; if the receiver stalls with a finished
// response pending, the next one holds in the final stage until it drains
// reset clears the count, the response valid and the control state; the
// element cells are not cleared, only entries below the count are ever read
module ordered_list_insert_remove_search
   import olirs_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int IW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int XW   = (CW > 7) ? CW : 7;
   localparam int NGRP = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int NPAD = NGRP * GROUP_SIZE;
   localparam int GW   = $clog2(NPAD);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_GRP,
      S_FIN
   } state_type;

   state_type      state_ff;
   req_type        req_ff;
   logic [CW-1:0]  count_ff, count_in;
   logic [1:0]     status_ff, status_in;
   logic           rsp_valid_ff;
   rsp_type        rsp_ff, rsp_in;

   cell_cmd_type   cmd;
   logic [IW-1:0]  cell_pos;

   logic signed [ELEM_W-1:0] cell_data [DEPTH];
   logic [DEPTH-1:0]         cell_hit;
   logic signed [ELEM_W-1:0] pad_data  [NPAD];
   logic [NPAD-1:0]          pad_hit;
   grp_type                  grp [NGRP];

   logic [XW-1:0]  pos_x, cnt_x;
   logic           is_full;
   logic           out_free;

   // ---------------------------------------------------------------------
   // command to the cell chain, worked out in the exec cycle
   // ---------------------------------------------------------------------
   assign pos_x   = XW'(req_ff.position);
   assign cnt_x   = XW'(count_ff);
   assign is_full = (count_ff == FULL_COUNT);

   always_comb begin
      cmd.op    = CELL_IDLE;
      cmd.value = req_ff.value;
      cell_pos  = '0;
      count_in  = count_ff;
      status_in = ST_OK;
      if (state_ff == S_EXEC) begin
         cmd.op = CELL_QUIET;
         case (req_ff.action)
            ACT_APPEND, ACT_INSERT: begin
               if (is_full) begin
                  status_in = ST_FULL;
               end else begin
                  cmd.op   = CELL_INSERT;
                  count_in = count_ff + 1'b1;
                  // append, or insert past the end, lands at the top
                  if (req_ff.action == ACT_APPEND || pos_x > cnt_x) begin
                     cell_pos = count_ff[IW-1:0];
                  end else begin
                     cell_pos = pos_x[IW-1:0];
                  end
               end
            end
            ACT_REMOVE: begin
               if (pos_x < cnt_x) begin
                  cmd.op   = CELL_REMOVE;
                  cell_pos = pos_x[IW-1:0];
                  count_in = count_ff - 1'b1;
               end
            end
            ACT_GET: begin
               if (count_ff == '0) begin
                  status_in = ST_EMPTY;
               end else begin
                  cmd.op = CELL_GET;
                  // out of range reads the last element
                  if (pos_x >= cnt_x) begin
                     cell_pos = IW'(count_ff - 1'b1);
                  end else begin
                     cell_pos = pos_x[IW-1:0];
                  end
               end
            end
            ACT_FIND:  cmd.op = CELL_FIND;
            ACT_CLEAR: count_in = '0;
            default:   cmd.op = CELL_QUIET;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // cell chain: each cell sees its lower and upper neighbour
   // ---------------------------------------------------------------------
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      olirs_cell #(
         .IW    (IW),
         .CW    (CW),
         .INDEX (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .pos       (cell_pos),
         .count     (count_ff),
         .prev_data (cell_data[(i == 0) ? 0 : i - 1]),
         .next_data (cell_data[(i == DEPTH - 1) ? DEPTH - 1 : i + 1]),
         .data      (cell_data[i]),
         .hit       (cell_hit[i])
      );
   end

   // pad the last group up to a full group of cells
   for (genvar i = 0; i < NPAD; i++) begin : g_pad
      if (i < DEPTH) begin : g_real
         assign pad_data[i] = cell_data[i];
         assign pad_hit[i]  = cell_hit[i];
      end else begin : g_zero
         assign pad_data[i] = '0;
         assign pad_hit[i]  = 1'b0;
      end
   end

   for (genvar g = 0; g < NGRP; g++) begin : g_grp
      olirs_group u_group (
         .clock (clock),
         .data  (pad_data[g*GROUP_SIZE +: GROUP_SIZE]),
         .hit   (pad_hit[g*GROUP_SIZE +: GROUP_SIZE]),
         .grp   (grp[g])
      );
   end

   // ---------------------------------------------------------------------
   // final pick across the groups
   // ---------------------------------------------------------------------
   always_comb begin
      logic [GW-1:0]            f_idx;
      logic                     f_any;
      logic signed [ELEM_W-1:0] f_data;
      f_idx  = '0;
      f_any  = 1'b0;
      f_data = '0;
      for (int g = NGRP - 1; g >= 0; g--) begin
         if (grp[g].any) begin
            f_any = 1'b1;
            f_idx = GW'(g * GROUP_SIZE) + GW'(grp[g].first);
         end
      end
      for (int g = 0; g < NGRP; g++) begin
         f_data = f_data | grp[g].data;
      end
      rsp_in.read_value  = (req_ff.action == ACT_GET) ? f_data : '0;
      rsp_in.found       = (req_ff.action == ACT_FIND) && f_any;
      rsp_in.found_index = rsp_in.found ? 6'(f_idx) : '0;
      rsp_in.count       = 7'(count_ff);
      rsp_in.status      = status_ff;
   end

   // ---------------------------------------------------------------------
   // sequencing and response register
   // ---------------------------------------------------------------------
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         status_ff    <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a response transfer empties the register unless a new one loads it
         if (rsp_valid_ff && rsp_ready && state_ff != S_FIN) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  req_ff   <= req_data;
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               count_ff  <= count_in;
               status_ff <= status_in;
               state_ff  <= S_GRP;
            end
            S_GRP: state_ff <= S_FIN;
            S_FIN: begin
               if (out_free) begin
                  rsp_ff       <= rsp_in;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire
